/* sv/kare_pkg.sv */
// -----------------------------------------------------------------------------
// kare_pkg
// Shared types and constants of the typematic key repeat engine.
// -----------------------------------------------------------------------------
`default_nettype none

package kare_pkg;

	localparam int unsigned CMD_W    = 2;
	localparam int unsigned KEY_W    = 5;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned TARGET_W = 8;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	// command codes
	localparam logic [CMD_W-1:0] CMD_DOWN = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UP   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

	// event kinds
	localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
	localparam logic [KIND_W-1:0] EV_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] EV_REPEAT  = 2'd2;

	// register indexes (paddr[2])
	localparam logic REG_DELAY    = 1'b0;
	localparam logic REG_INTERVAL = 1'b1;

	localparam logic [CFG_W-1:0] DELAY_RST    = 16'd300;
	localparam logic [CFG_W-1:0] INTERVAL_RST = 16'd30;

	localparam logic [TARGET_W-1:0] NO_TARGET = 8'd0;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [KEY_W-1:0]    key_index;
		logic [TIME_W-1:0]   time_now_ms;
		logic [TARGET_W-1:0] focus_id;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0]   event_kind;
		logic [KEY_W-1:0]    key_code;
		logic [TARGET_W-1:0] target_id;
		logic                last_of_run;
	} evt_t;

	typedef struct packed {
		logic [CFG_W-1:0] initial_delay_ms;
		logic [CFG_W-1:0] repeat_interval_ms;
	} cfg_t;

	// wrap-safe "now is strictly later than due"
	function automatic logic time_later(input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] due);
		logic [TIME_W-1:0] d;
		d = now - due;
		return (d != '0) && !d[TIME_W-1];
	endfunction

endpackage

`default_nettype wire

/* sv/kare_cmd_if.sv */
// -----------------------------------------------------------------------------
// kare_cmd_if
// Input channel: key down, key up and time tick commands.
// -----------------------------------------------------------------------------
`default_nettype none

interface kare_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [kare_pkg::CMD_W-1:0]     command;
	logic [kare_pkg::KEY_W-1:0]     key_index;
	logic [kare_pkg::TIME_W-1:0]    time_now_ms;
	logic [kare_pkg::TARGET_W-1:0]  focus_id;

	modport source (output valid, command, key_index, time_now_ms, focus_id, input ready);
	modport sink   (input valid, command, key_index, time_now_ms, focus_id, output ready);
endinterface

`default_nettype wire

/* sv/kare_evt_if.sv */
// -----------------------------------------------------------------------------
// kare_evt_if
// Output channel: press, release and repeat events.
// -----------------------------------------------------------------------------
`default_nettype none

interface kare_evt_if;
	logic                           valid;
	logic                           ready;
	logic [kare_pkg::KIND_W-1:0]    event_kind;
	logic [kare_pkg::KEY_W-1:0]     key_code;
	logic [kare_pkg::TARGET_W-1:0]  target_id;
	logic                           last_of_run;

	modport source (output valid, event_kind, key_code, target_id, last_of_run, input ready);
	modport sink   (input valid, event_kind, key_code, target_id, last_of_run, output ready);
endinterface

`default_nettype wire

/* sv/kare_cfg_regs.sv */
// -----------------------------------------------------------------------------
// kare_cfg_regs
// APB-style register file: initial delay and repeat interval.
// -----------------------------------------------------------------------------
`default_nettype none

module kare_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [kare_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [kare_pkg::PDATA_W-1:0]  pwdata,
	output logic      [kare_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	output kare_pkg::cfg_t                     cfg
);

	logic [kare_pkg::CFG_W-1:0] delay_q;
	logic [kare_pkg::CFG_W-1:0] interval_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= kare_pkg::DELAY_RST;
			interval_q <= kare_pkg::INTERVAL_RST;
		end else if (wr_en) begin
			if (paddr[2] == kare_pkg::REG_DELAY) begin
				delay_q <= pwdata[kare_pkg::CFG_W-1:0];
			end else begin
				interval_q <= pwdata[kare_pkg::CFG_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == kare_pkg::REG_DELAY) begin
			prdata = kare_pkg::PDATA_W'(delay_q);
		end else begin
			prdata = kare_pkg::PDATA_W'(interval_q);
		end
	end

	assign cfg.initial_delay_ms   = delay_q;
	assign cfg.repeat_interval_ms = interval_q;

endmodule

`default_nettype wire

/* sv/kare_time_mem.sv */
// -----------------------------------------------------------------------------
// kare_time_mem
// Next-repeat-time store: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module kare_time_mem #(
	parameter int unsigned DEPTH  = 32,
	parameter int unsigned ADDR_W = 5
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [ADDR_W-1:0]             waddr,
	input  wire logic [kare_pkg::TIME_W-1:0]   wdata,
	input  wire logic                          re,
	input  wire logic [ADDR_W-1:0]             raddr,
	output logic      [kare_pkg::TIME_W-1:0]   rdata
);

	logic [kare_pkg::TIME_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/kare_scan.sv */
// -----------------------------------------------------------------------------
// kare_scan
// Command sequencer: held bits, stored target, tick scan over the time store,
// one-deep pending result and the output register.
// -----------------------------------------------------------------------------
`default_nettype none

module kare_scan #(
	parameter int unsigned NUM_KEYS = 32,
	parameter int unsigned ADDR_W   = 5,
	parameter int unsigned CNT_W    = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire kare_pkg::cmd_t                in_cmd,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output kare_pkg::evt_t                     out_evt,
	input  wire kare_pkg::cfg_t                cfg,
	output logic                               mem_we,
	output logic      [ADDR_W-1:0]             mem_waddr,
	output logic      [kare_pkg::TIME_W-1:0]   mem_wdata,
	output logic                               mem_re,
	output logic      [ADDR_W-1:0]             mem_raddr,
	input  wire logic [kare_pkg::TIME_W-1:0]   mem_rdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t                         state_q;
	logic [NUM_KEYS-1:0]            held_q;
	logic [kare_pkg::TARGET_W-1:0]  stored_target_q;
	logic [kare_pkg::TIME_W-1:0]    now_q;
	logic [kare_pkg::TARGET_W-1:0]  focus_q;
	logic [CNT_W-1:0]               issue_cnt_q;
	logic                           ev_v_s1;
	logic [ADDR_W-1:0]              ev_idx_s1;
	logic                           pend_v_q;
	kare_pkg::evt_t                 pend_q;
	logic                           out_v_q;
	kare_pkg::evt_t                 out_q;

	logic              accept;
	logic              in_range;
	logic [ADDR_W-1:0] key_addr;
	logic              down_new;
	logic              tick_scan;
	logic              more_keys;
	logic              ev_due;
	logic              out_free;
	logic              stall;

	always_comb begin
		accept    = in_valid && in_ready;
		in_range  = 7'(in_cmd.key_index) < 7'(NUM_KEYS);
		key_addr  = ADDR_W'(in_cmd.key_index);
		down_new  = (in_cmd.command == kare_pkg::CMD_DOWN) && in_range && !held_q[key_addr];
		tick_scan = (in_cmd.command == kare_pkg::CMD_TICK)
			&& (in_cmd.focus_id != kare_pkg::NO_TARGET)
			&& (in_cmd.focus_id == stored_target_q);
		more_keys = issue_cnt_q < CNT_W'(NUM_KEYS);
		ev_due    = ev_v_s1 && held_q[ev_idx_s1] && kare_pkg::time_later(now_q, mem_rdata);
		out_free  = !out_v_q || out_ready;
		// a second result needs the output register before the pending one moves on
		stall     = (state_q == ST_SCAN) && ev_due && pend_v_q && !out_free;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_v_q;
	assign out_evt   = out_q;

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = key_addr;
		mem_wdata = in_cmd.time_now_ms + kare_pkg::TIME_W'(cfg.initial_delay_ms);
		if (accept) begin
			mem_re = tick_scan;
			mem_we = down_new;
		end else if (state_q == ST_SCAN && !stall) begin
			mem_re    = more_keys;
			mem_raddr = issue_cnt_q[ADDR_W-1:0];
			mem_we    = ev_due;
			mem_waddr = ev_idx_s1;
			mem_wdata = now_q + kare_pkg::TIME_W'(cfg.repeat_interval_ms);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			held_q          <= '0;
			stored_target_q <= kare_pkg::NO_TARGET;
			ev_v_s1         <= 1'b0;
			pend_v_q        <= 1'b0;
			out_v_q         <= 1'b0;
			issue_cnt_q     <= '0;
		end else begin
			if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_cmd.command)
							kare_pkg::CMD_DOWN: begin
								if (down_new) begin
									held_q[key_addr] <= 1'b1;
									stored_target_q  <= in_cmd.focus_id;
									if (in_cmd.focus_id != kare_pkg::NO_TARGET) begin
										pend_q.event_kind  <= kare_pkg::EV_PRESS;
										pend_q.key_code    <= in_cmd.key_index;
										pend_q.target_id   <= in_cmd.focus_id;
										pend_q.last_of_run <= 1'b0;
										pend_v_q           <= 1'b1;
										state_q            <= ST_FLUSH;
									end
								end
							end
							kare_pkg::CMD_UP: begin
								if (in_range && held_q[key_addr]) begin
									held_q[key_addr] <= 1'b0;
									if (in_cmd.focus_id != kare_pkg::NO_TARGET) begin
										pend_q.event_kind  <= kare_pkg::EV_RELEASE;
										pend_q.key_code    <= in_cmd.key_index;
										pend_q.target_id   <= in_cmd.focus_id;
										pend_q.last_of_run <= 1'b0;
										pend_v_q           <= 1'b1;
										state_q            <= ST_FLUSH;
									end
								end
							end
							kare_pkg::CMD_TICK: begin
								if (tick_scan) begin
									now_q       <= in_cmd.time_now_ms;
									focus_q     <= in_cmd.focus_id;
									ev_v_s1     <= 1'b1;
									ev_idx_s1   <= '0;
									issue_cnt_q <= CNT_W'(1);
									state_q     <= ST_SCAN;
								end else if (in_cmd.focus_id != kare_pkg::NO_TARGET) begin
									// focus moved away: drop every held key
									held_q <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (!stall) begin
						if (ev_due) begin
							pend_q.event_kind  <= kare_pkg::EV_REPEAT;
							pend_q.key_code    <= kare_pkg::KEY_W'(ev_idx_s1);
							pend_q.target_id   <= focus_q;
							pend_q.last_of_run <= 1'b0;
							pend_v_q           <= 1'b1;
							if (pend_v_q) begin
								out_q   <= pend_q;
								out_v_q <= 1'b1;
							end
						end
						if (more_keys) begin
							ev_v_s1     <= 1'b1;
							ev_idx_s1   <= issue_cnt_q[ADDR_W-1:0];
							issue_cnt_q <= issue_cnt_q + CNT_W'(1);
						end else begin
							ev_v_s1 <= 1'b0;
						end
						if (!ev_v_s1) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_q             <= pend_q;
						out_q.last_of_run <= 1'b1;
						out_v_q           <= 1'b1;
						pend_v_q          <= 1'b0;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/key_auto_repeat_engine.sv */
// -----------------------------------------------------------------------------
// key_auto_repeat_engine
// Typematic auto-repeat: tracks held keys and emits press, release and
// repeat events to the focused target.
// -----------------------------------------------------------------------------
// Usage:
//   cmd  (sink)   : one transaction per key down, key up or time tick.
//   evt  (source) : press / release / repeat events; last_of_run marks the
//                   final event caused by one command.
//   APB port      : initial delay at 0x0, repeat interval at 0x4 (16 bits).
// Timing:
//   Key down and key up keep ready high when they produce no event; one that
//   does passes through the flush state until the output register is free.
//   A tick walks the next-repeat-time store one key per cycle through its
//   single read port, pausing while the receiver holds back an event and
//   another is pending.
//   An event waits in a one-deep slot until the next due key or the end of
//   the scan settles its last_of_run, so repeat events trail the scan.
// Reset:
//   All keys released, stored target cleared, registers at 300 ms and 30 ms.
//   The time store needs no clearing; an entry is used only while its key
//   is held.
// Stall:
//   The output register keeps its event until taken; the scan pauses once a
//   second event is waiting behind it. cmd.ready is low while a command runs.
// -----------------------------------------------------------------------------
`default_nettype none

module key_auto_repeat_engine #(
	parameter int unsigned NUM_KEYS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	kare_cmd_if.sink                           cmd,
	kare_evt_if.source                         evt,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [kare_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [kare_pkg::PDATA_W-1:0]  pwdata,
	output logic      [kare_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready
);

	localparam int unsigned ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int unsigned CNT_W  = $clog2(NUM_KEYS + 1);

	kare_pkg::cfg_t                cfg;
	kare_pkg::cmd_t                in_cmd;
	kare_pkg::evt_t                out_evt;
	logic                          mem_we;
	logic [ADDR_W-1:0]             mem_waddr;
	logic [kare_pkg::TIME_W-1:0]   mem_wdata;
	logic                          mem_re;
	logic [ADDR_W-1:0]             mem_raddr;
	logic [kare_pkg::TIME_W-1:0]   mem_rdata;
	logic                          out_valid;
	logic                          in_ready;

	assign in_cmd.command     = cmd.command;
	assign in_cmd.key_index   = cmd.key_index;
	assign in_cmd.time_now_ms = cmd.time_now_ms;
	assign in_cmd.focus_id    = cmd.focus_id;
	assign cmd.ready          = in_ready;

	assign evt.valid       = out_valid;
	assign evt.event_kind  = out_evt.event_kind;
	assign evt.key_code    = out_evt.key_code;
	assign evt.target_id   = out_evt.target_id;
	assign evt.last_of_run = out_evt.last_of_run;

	kare_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kare_time_mem #(
		.DEPTH  (NUM_KEYS),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	kare_scan #(
		.NUM_KEYS (NUM_KEYS),
		.ADDR_W   (ADDR_W),
		.CNT_W    (CNT_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (in_ready),
		.in_cmd    (in_cmd),
		.out_valid (out_valid),
		.out_ready (evt.ready),
		.out_evt   (out_evt),
		.cfg       (cfg),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

`default_nettype wire

/* sv/kare_checker.sv */
// -----------------------------------------------------------------------------
// kare_checker
// Port-level checks of the key repeat engine, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

module kare_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          evt_valid,
	input wire logic                          evt_ready,
	input wire logic [kare_pkg::KIND_W-1:0]   evt_event_kind,
	input wire logic [kare_pkg::TARGET_W-1:0] evt_target_id,
	input wire logic                          evt_last_of_run
);

	// a stalled event stays offered
	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid)
		else $error("event dropped while stalled");

	a_target_set: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> evt_target_id != kare_pkg::NO_TARGET)
		else $error("event without a target");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> (evt_event_kind == kare_pkg::EV_PRESS
			|| evt_event_kind == kare_pkg::EV_RELEASE
			|| evt_event_kind == kare_pkg::EV_REPEAT))
		else $error("unknown event kind");

	// press and release are the only event of their command
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_event_kind != kare_pkg::EV_REPEAT |-> evt_last_of_run)
		else $error("press or release not marked last");

	// a stalled event keeps its kind, target and last_of_run
	a_evt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> $stable(evt_event_kind) && $stable(evt_target_id)
			&& $stable(evt_last_of_run))
		else $error("event changed while stalled");

endmodule

bind key_auto_repeat_engine kare_checker u_kare_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.evt_valid       (evt.valid),
	.evt_ready       (evt.ready),
	.evt_event_kind  (evt.event_kind),
	.evt_target_id   (evt.target_id),
	.evt_last_of_run (evt.last_of_run)
);

`default_nettype wire

/* sim/key_auto_repeat_engine_tb.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// key_auto_repeat_engine_tb
// Self-checking bench for the typematic repeat engine. A behavioral model
// tracks held keys, due times and the owning target, predicts the press,
// release and repeat events of every accepted command and matches them in
// order against the event channel. Both channels stall at random, and the
// delay and interval registers are moved through several settings over APB.
// -----------------------------------------------------------------------------
module key_auto_repeat_engine_tb;

	localparam int NUM_KEYS     = 32;
	localparam int PHASE_ITEMS  = 34;
	localparam logic [kare_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
	localparam logic [kare_pkg::PADDR_W-1:0] ADDR_DELAY    = {kare_pkg::REG_DELAY, 2'b00};
	localparam logic [kare_pkg::PADDR_W-1:0] ADDR_INTERVAL = {kare_pkg::REG_INTERVAL, 2'b00};

	class typematic_model;
		logic [kare_pkg::CFG_W-1:0]    delay_ms;
		logic [kare_pkg::CFG_W-1:0]    interval_ms;
		bit                            held [NUM_KEYS];
		logic [kare_pkg::TIME_W-1:0]   due_ms [NUM_KEYS];
		logic [kare_pkg::TARGET_W-1:0] owner;
		kare_pkg::evt_t                due_events [$];
		int                            errors;

		function new();
			delay_ms    = kare_pkg::DELAY_RST;
			interval_ms = kare_pkg::INTERVAL_RST;
			owner       = kare_pkg::NO_TARGET;
			errors      = 0;
			foreach (held[i]) begin
				held[i]   = 1'b0;
				due_ms[i] = '0;
			end
		endfunction

		function void write_reg(logic sel, logic [kare_pkg::CFG_W-1:0] value);
			if (sel == kare_pkg::REG_DELAY) begin
				delay_ms = value;
			end else begin
				interval_ms = value;
			end
		endfunction

		// wrap-safe: now lies 1 .. 2^31-1 ms past due
		function bit is_past(logic [kare_pkg::TIME_W-1:0] now,
				logic [kare_pkg::TIME_W-1:0] due);
			logic [kare_pkg::TIME_W-1:0] gap;
			gap = now - due;
			return (gap != '0) && !gap[kare_pkg::TIME_W-1];
		endfunction

		function kare_pkg::evt_t make_event(logic [kare_pkg::KIND_W-1:0] kind,
				logic [kare_pkg::KEY_W-1:0] key, logic [kare_pkg::TARGET_W-1:0] target);
			kare_pkg::evt_t e;
			e.event_kind  = kind;
			e.key_code    = key;
			e.target_id   = target;
			e.last_of_run = 1'b0;
			return e;
		endfunction

		function void apply_command(kare_pkg::cmd_t c);
			kare_pkg::evt_t run [$];
			case (c.command)
			kare_pkg::CMD_DOWN: begin
				if (c.key_index < NUM_KEYS && !held[c.key_index]) begin
					held[c.key_index]   = 1'b1;
					due_ms[c.key_index] = c.time_now_ms + kare_pkg::TIME_W'(delay_ms);
					owner               = c.focus_id;
					if (c.focus_id != kare_pkg::NO_TARGET)
						run.push_back(make_event(kare_pkg::EV_PRESS, c.key_index,
							c.focus_id));
				end
			end
			kare_pkg::CMD_UP: begin
				if (c.key_index < NUM_KEYS && held[c.key_index]) begin
					held[c.key_index] = 1'b0;
					if (c.focus_id != kare_pkg::NO_TARGET)
						run.push_back(make_event(kare_pkg::EV_RELEASE, c.key_index,
							c.focus_id));
				end
			end
			kare_pkg::CMD_TICK: begin
				if (c.focus_id != kare_pkg::NO_TARGET) begin
					for (int k = 0; k < NUM_KEYS; k++) begin
						if (held[k]) begin
							if (owner != c.focus_id) begin
								// focus moved away: drop without an event
								held[k] = 1'b0;
							end else if (is_past(c.time_now_ms, due_ms[k])) begin
								due_ms[k] = c.time_now_ms + kare_pkg::TIME_W'(interval_ms);
								run.push_back(make_event(kare_pkg::EV_REPEAT,
									kare_pkg::KEY_W'(k), c.focus_id));
							end
						end
					end
				end
			end
			default: ;
			endcase
			if (run.size() > 0)
				run[run.size()-1].last_of_run = 1'b1;
			foreach (run[i])
				due_events.push_back(run[i]);
		endfunction

		task flag_mismatch(string msg);
			errors++;
			$display("%0t ERROR %s", $time, msg);
		endtask

		task match_event(kare_pkg::evt_t got);
			kare_pkg::evt_t want;
			if (due_events.size() == 0) begin
				flag_mismatch($sformatf("unexpected event kind=%0d key=%0d target=%0d last=%0b",
					got.event_kind, got.key_code, got.target_id, got.last_of_run));
				return;
			end
			want = due_events.pop_front();
			if (got.event_kind !== want.event_kind || got.key_code !== want.key_code ||
					got.target_id !== want.target_id || got.last_of_run !== want.last_of_run)
				flag_mismatch($sformatf(
					"event got kind=%0d key=%0d target=%0d last=%0b, want %0d %0d %0d %0b",
					got.event_kind, got.key_code, got.target_id, got.last_of_run,
					want.event_kind, want.key_code, want.target_id, want.last_of_run));
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [kare_pkg::PADDR_W-1:0]  paddr;
	logic [kare_pkg::PDATA_W-1:0]  pwdata;
	logic [kare_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;

	kare_cmd_if cmd_ch ();
	kare_evt_if evt_ch ();

	typematic_model                tm;
	int                            src_gap;
	int                            src_calm;
	int                            sink_calm;
	int                            sent_items;
	logic [kare_pkg::TIME_W-1:0]   now_ms;

	key_auto_repeat_engine #(.NUM_KEYS(NUM_KEYS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.evt     (evt_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	// quiet stretches now and then, otherwise a wait drawn at random
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	function automatic logic [kare_pkg::TIME_W-1:0] step_ms();
		int widest;
		widest = (tm.delay_ms > tm.interval_ms) ? int'(tm.delay_ms) : int'(tm.interval_ms);
		case ($urandom_range(0, 9))
		0: return '0;
		1: return $urandom;
		default: return $urandom_range(0, widest + 2);
		endcase
	endfunction

	task automatic push_command(logic [kare_pkg::CMD_W-1:0] op,
			logic [kare_pkg::KEY_W-1:0] key, logic [kare_pkg::TIME_W-1:0] at_ms,
			logic [kare_pkg::TARGET_W-1:0] focus);
		kare_pkg::cmd_t c;
		c.command     = op;
		c.key_index   = key;
		c.time_now_ms = at_ms;
		c.focus_id    = focus;
		repeat (src_gap) @(negedge clk);
		cmd_ch.command     <= op;
		cmd_ch.key_index   <= key;
		cmd_ch.time_now_ms <= at_ms;
		cmd_ch.focus_id    <= focus;
		cmd_ch.valid       <= 1'b1;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		tm.apply_command(c);
		if (op != CMD_NONE)
			sent_items++;
		@(negedge clk);
		// keep valid up when the next transaction follows at once
		src_gap = draw_wait(src_calm);
		if (src_gap > 0)
			cmd_ch.valid <= 1'b0;
	endtask

	// wait for every event, then let a possible silent tick finish
	task automatic settle();
		if (src_gap == 0)
			cmd_ch.valid <= 1'b0;
		while (tm.due_events.size() != 0) @(posedge clk);
		repeat (NUM_KEYS + 8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_write(logic [kare_pkg::PADDR_W-1:0] addr,
			logic [kare_pkg::PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(logic [kare_pkg::PADDR_W-1:0] addr,
			output logic [kare_pkg::PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		data = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(logic [kare_pkg::CFG_W-1:0] delay,
			logic [kare_pkg::CFG_W-1:0] interval);
		logic [kare_pkg::PDATA_W-1:0] rd;
		settle();
		apb_write(ADDR_DELAY, kare_pkg::PDATA_W'(delay));
		tm.write_reg(kare_pkg::REG_DELAY, delay);
		apb_write(ADDR_INTERVAL, kare_pkg::PDATA_W'(interval));
		tm.write_reg(kare_pkg::REG_INTERVAL, interval);
		apb_read(ADDR_DELAY, rd);
		if (rd !== kare_pkg::PDATA_W'(delay))
			tm.flag_mismatch($sformatf("delay reads %0h, want %0h", rd, delay));
		apb_read(ADDR_INTERVAL, rd);
		if (rd !== kare_pkg::PDATA_W'(interval))
			tm.flag_mismatch($sformatf("interval reads %0h, want %0h", rd, interval));
	endtask

	task automatic make_noise();
		case ($urandom_range(0, 4))
		0: push_command(CMD_NONE, kare_pkg::KEY_W'($urandom), $urandom,
				kare_pkg::TARGET_W'($urandom));
		1: push_command(kare_pkg::CMD_TICK, kare_pkg::KEY_W'($urandom), now_ms,
				kare_pkg::NO_TARGET);
		2: push_command($urandom_range(0, 1) ? kare_pkg::CMD_UP : kare_pkg::CMD_DOWN,
				kare_pkg::KEY_W'($urandom), now_ms, kare_pkg::NO_TARGET);
		3: push_command(kare_pkg::CMD_DOWN, kare_pkg::KEY_W'($urandom), $urandom,
				kare_pkg::TARGET_W'($urandom));
		default: push_command(kare_pkg::CMD_UP, kare_pkg::KEY_W'($urandom), now_ms,
				kare_pkg::TARGET_W'($urandom));
		endcase
	endtask

	// press a group of keys for one target, tick past the delay, repeat, release
	task automatic run_session();
		logic [kare_pkg::TARGET_W-1:0] f;
		int nk;
		int base;
		int nt;
		f = kare_pkg::TARGET_W'($urandom_range(1, 255));
		if ($urandom_range(0, 6) == 0)
			nk = $urandom_range(16, NUM_KEYS);
		else
			nk = $urandom_range(1, 4);
		base = $urandom_range(0, NUM_KEYS - 1);
		for (int i = 0; i < nk; i++) begin
			if ($urandom_range(0, 11) == 0)
				make_noise();
			now_ms += $urandom_range(0, 3);
			push_command(kare_pkg::CMD_DOWN, kare_pkg::KEY_W'((base + i) % NUM_KEYS),
				now_ms, f);
		end
		now_ms += kare_pkg::TIME_W'(tm.delay_ms) + $urandom_range(1, 100);
		push_command(kare_pkg::CMD_TICK, kare_pkg::KEY_W'($urandom), now_ms, f);
		nt = $urandom_range(1, 6);
		for (int j = 0; j < nt; j++) begin
			if ($urandom_range(0, 5) == 0)
				make_noise();
			now_ms += step_ms();
			case ($urandom_range(0, 9))
			0: push_command(kare_pkg::CMD_DOWN, kare_pkg::KEY_W'($urandom), now_ms, f);
			1: push_command(kare_pkg::CMD_UP, kare_pkg::KEY_W'($urandom), now_ms,
					($urandom_range(0, 3) == 0) ? kare_pkg::NO_TARGET : f);
			default: push_command(kare_pkg::CMD_TICK, kare_pkg::KEY_W'($urandom), now_ms, f);
			endcase
		end
		if ($urandom_range(0, 4) == 0) begin
			now_ms += step_ms();
			push_command(kare_pkg::CMD_TICK, kare_pkg::KEY_W'($urandom), now_ms,
				f ^ kare_pkg::TARGET_W'($urandom_range(1, 255)));
		end
		repeat ($urandom_range(0, nk))
			push_command(kare_pkg::CMD_UP,
				kare_pkg::KEY_W'((base + $urandom_range(0, nk - 1)) % NUM_KEYS), now_ms,
				($urandom_range(0, 7) == 0) ? kare_pkg::NO_TARGET : f);
	endtask

	task automatic run_phase();
		int start;
		start = sent_items;
		while (sent_items - start < PHASE_ITEMS)
			run_session();
	endtask

	task automatic directed_checks();
		logic [kare_pkg::TIME_W-1:0] tt;
		tt = 32'hFFFF_FF00;
		push_command(CMD_NONE, 5'd31, tt, 8'hFF);
		push_command(kare_pkg::CMD_UP, 5'd0, tt, 8'hFF);
		push_command(kare_pkg::CMD_TICK, 5'd0, tt, kare_pkg::NO_TARGET);
		// due times wrap past zero
		push_command(kare_pkg::CMD_DOWN, 5'd0, tt, 8'hFF);
		push_command(kare_pkg::CMD_DOWN, 5'd31, tt, 8'hFF);
		push_command(kare_pkg::CMD_DOWN, 5'd0, tt + 5, 8'hFF);
		push_command(kare_pkg::CMD_TICK, 5'd9, tt + 300, 8'hFF);
		push_command(kare_pkg::CMD_TICK, 5'd0, tt + 301, 8'hFF);
		// half the time circle ahead counts as not later, one less does
		push_command(kare_pkg::CMD_TICK, 5'd0, tt + 331 + 32'h8000_0000, 8'hFF);
		tt = tt + 331 + 32'h7FFF_FFFF;
		push_command(kare_pkg::CMD_TICK, 5'd0, tt, 8'hFF);
		push_command(kare_pkg::CMD_UP, 5'd31, tt, kare_pkg::NO_TARGET);
		push_command(kare_pkg::CMD_DOWN, 5'd5, tt, kare_pkg::NO_TARGET);
		// owner is now no target, so the next tick drops everything
		push_command(kare_pkg::CMD_TICK, 5'd0, tt + 1000, 8'hFF);
		push_command(kare_pkg::CMD_TICK, 5'd0, tt + 2000, 8'hFF);
		push_command(kare_pkg::CMD_DOWN, 5'd3, tt, 8'h01);
		push_command(kare_pkg::CMD_DOWN, 5'd4, tt, 8'h80);
		push_command(kare_pkg::CMD_TICK, 5'd0, tt + 301, 8'h80);
		push_command(kare_pkg::CMD_UP, 5'd4, tt + 302, 8'h7F);
		push_command(kare_pkg::CMD_TICK, 5'd0, tt + 400, 8'h01);
		push_command(kare_pkg::CMD_UP, 5'd3, tt + 401, 8'h55);
		now_ms = tt + 500;
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_wait(sink_calm);
			if (stall > 0) begin
				evt_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			evt_ch.ready <= 1'b1;
			do @(posedge clk); while (evt_ch.valid !== 1'b1);
			tm.match_event({evt_ch.event_kind, evt_ch.key_code, evt_ch.target_id,
				evt_ch.last_of_run});
			@(negedge clk);
		end
	end

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.command     = kare_pkg::CMD_DOWN;
		cmd_ch.key_index   = '0;
		cmd_ch.time_now_ms = '0;
		cmd_ch.focus_id    = kare_pkg::NO_TARGET;
		evt_ch.ready       = 1'b0;
		src_gap            = 0;
		src_calm           = 0;
		sink_calm          = 0;
		sent_items         = 0;
		now_ms             = '0;
		tm                 = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_checks();
		run_phase();
		set_config(16'd1, 16'd1);
		run_phase();
		set_config(16'hFFFF, 16'hFFFF);
		run_phase();
		set_config(16'd1, 16'hFFFF);
		run_phase();
		set_config(16'hFFFF, 16'd1);
		run_phase();
		set_config(kare_pkg::CFG_W'($urandom_range(1, 65535)),
			kare_pkg::CFG_W'($urandom_range(1, 65535)));
		run_phase();
		settle();

		if (tm.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
sv/kare_pkg.sv
sv/kare_cmd_if.sv
sv/kare_evt_if.sv
sv/kare_cfg_regs.sv
sv/kare_time_mem.sv
sv/kare_scan.sv
sv/key_auto_repeat_engine.sv
sv/kare_checker.sv
sim/key_auto_repeat_engine_tb.sv
